// ===== design/octahedral_normal_encoder_assert.svh =====
// Assertion macros used by the checker file.
`ifndef OCTAHEDRAL_NORMAL_ENCODER_ASSERT_SVH
`define OCTAHEDRAL_NORMAL_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define OCT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("octahedral encoder check failed");

// Next-cycle implication, disabled while reset is high.
`define OCT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("octahedral encoder check failed");

`endif

// ===== design/oct_pkg.sv =====
`default_nettype none

package oct_pkg;

   // quotient bits of one snorm16 coordinate magnitude (|q| <= 32767)
   localparam int SNORM_BITS = 15;
   localparam int HALF_BITS  = 16;
   // three front stages, SNORM_BITS-1 divider cells, one output stage
   localparam int PIPE_DEPTH = SNORM_BITS + 3;

   typedef struct packed {
      logic neg_x;
      logic neg_y;
   } side_type;

endpackage

`default_nettype wire

// ===== design/oct_if.sv =====
`default_nettype none

interface oct_req_if #(parameter int COMPONENT_BITS = 16);
   logic                             valid;
   logic                             ready;
   logic signed [COMPONENT_BITS-1:0] dir_x;
   logic signed [COMPONENT_BITS-1:0] dir_y;
   logic signed [COMPONENT_BITS-1:0] dir_z;

   modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
   modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface oct_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] packed_normal;

   modport source (output valid, output packed_normal, input ready);
   modport sink   (input valid, input packed_normal, output ready);
endinterface

`default_nettype wire

// ===== design/oct_prep.sv =====
`default_nettype none

module oct_prep #(
   parameter int COMPONENT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   oct_req_if.sink                           up,
   output logic                              dn_valid,
   input  logic                              dn_ready,
   output logic [COMPONENT_BITS:0]           dn_rem_x,
   output logic [COMPONENT_BITS:0]           dn_rem_y,
   output logic [oct_pkg::SNORM_BITS-1:0]    dn_word_x,
   output logic [oct_pkg::SNORM_BITS-1:0]    dn_word_y,
   output logic [COMPONENT_BITS:0]           dn_div,
   output oct_pkg::side_type                 dn_side
);
   import oct_pkg::*;

   localparam int CB  = COMPONENT_BITS;
   localparam int L1W = COMPONENT_BITS + 1;
   localparam int NW  = L1W + SNORM_BITS;

   // stage 1: magnitudes and signs
   logic           s1_valid_ff, s1_valid_in, s1_ready;
   logic [CB-1:0]  s1_ax_ff, s1_ay_ff, s1_az_ff;
   logic [CB-1:0]  s1_ax_in, s1_ay_in, s1_az_in;
   logic           s1_fold_ff, s1_fold_in;
   side_type       s1_side_ff, s1_side_in;

   // stage 2: L1 norm and numerator magnitudes
   logic           s2_valid_ff, s2_valid_in, s2_ready;
   logic [L1W-1:0] s2_l1_ff, s2_mx_ff, s2_my_ff;
   logic [L1W-1:0] s2_l1_in, s2_mx_in, s2_my_in;
   side_type       s2_side_ff;

   // stage 3: dividends m * 32767, split into initial remainder and low bits
   logic                  s3_valid_ff, s3_valid_in, s3_ready;
   logic [NW-1:0]         s3_nx_in, s3_ny_in;
   logic [L1W-1:0]        s3_rem_x_ff, s3_rem_y_ff, s3_div_ff;
   logic [SNORM_BITS-1:0] s3_word_x_ff, s3_word_y_ff;
   side_type              s3_side_ff;

   logic [CB-1:0] ux, uy, uz;

   assign s3_ready = !s3_valid_ff || dn_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign up.ready = s1_ready;

   always_comb begin
      ux = $unsigned(up.dir_x);
      uy = $unsigned(up.dir_y);
      uz = $unsigned(up.dir_z);
      s1_ax_in = ux[CB-1] ? ('0 - ux) : ux;
      s1_ay_in = uy[CB-1] ? ('0 - uy) : uy;
      s1_az_in = uz[CB-1] ? ('0 - uz) : uz;
      s1_fold_in = uz[CB-1];
      s1_side_in.neg_x = ux[CB-1];
      s1_side_in.neg_y = uy[CB-1];
      s1_valid_in = s1_ready ? up.valid : s1_valid_ff;
   end

   always_comb begin
      s2_l1_in = L1W'(s1_ax_ff) + L1W'(s1_ay_ff) + L1W'(s1_az_ff);
      // folded: L1 - |y| is |x| + |z|, and L1 - |x| is |y| + |z|
      s2_mx_in = s1_fold_ff ? (L1W'(s1_ax_ff) + L1W'(s1_az_ff)) : L1W'(s1_ax_ff);
      s2_my_in = s1_fold_ff ? (L1W'(s1_ay_ff) + L1W'(s1_az_ff)) : L1W'(s1_ay_ff);
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   end

   always_comb begin
      s3_nx_in = {s2_mx_ff, {SNORM_BITS{1'b0}}} - NW'(s2_mx_ff);
      s3_ny_in = {s2_my_ff, {SNORM_BITS{1'b0}}} - NW'(s2_my_ff);
      s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && up.valid) begin
         s1_ax_ff   <= s1_ax_in;
         s1_ay_ff   <= s1_ay_in;
         s1_az_ff   <= s1_az_in;
         s1_fold_ff <= s1_fold_in;
         s1_side_ff <= s1_side_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_l1_ff   <= s2_l1_in;
         s2_mx_ff   <= s2_mx_in;
         s2_my_ff   <= s2_my_in;
         s2_side_ff <= s1_side_ff;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_rem_x_ff  <= s3_nx_in[NW-1:SNORM_BITS];
         s3_rem_y_ff  <= s3_ny_in[NW-1:SNORM_BITS];
         s3_word_x_ff <= s3_nx_in[SNORM_BITS-1:0];
         s3_word_y_ff <= s3_ny_in[SNORM_BITS-1:0];
         s3_div_ff    <= s2_l1_ff;
         s3_side_ff   <= s2_side_ff;
      end
   end

   assign dn_valid  = s3_valid_ff;
   assign dn_rem_x  = s3_rem_x_ff;
   assign dn_rem_y  = s3_rem_y_ff;
   assign dn_word_x = s3_word_x_ff;
   assign dn_word_y = s3_word_y_ff;
   assign dn_div    = s3_div_ff;
   assign dn_side   = s3_side_ff;

endmodule

`default_nettype wire

// ===== design/oct_div_cell.sv =====
`default_nettype none

module oct_div_cell #(
   parameter int COMPONENT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              up_valid,
   output logic                              up_ready,
   input  logic [COMPONENT_BITS:0]           up_rem_x,
   input  logic [COMPONENT_BITS:0]           up_rem_y,
   input  logic [oct_pkg::SNORM_BITS-1:0]    up_word_x,
   input  logic [oct_pkg::SNORM_BITS-1:0]    up_word_y,
   input  logic [COMPONENT_BITS:0]           up_div,
   input  oct_pkg::side_type                 up_side,
   output logic                              dn_valid,
   input  logic                              dn_ready,
   output logic [COMPONENT_BITS:0]           dn_rem_x,
   output logic [COMPONENT_BITS:0]           dn_rem_y,
   output logic [oct_pkg::SNORM_BITS-1:0]    dn_word_x,
   output logic [oct_pkg::SNORM_BITS-1:0]    dn_word_y,
   output logic [COMPONENT_BITS:0]           dn_div,
   output oct_pkg::side_type                 dn_side
);
   import oct_pkg::*;

   localparam int L1W = COMPONENT_BITS + 1;

   logic                  valid_ff, valid_in;
   logic [L1W-1:0]        rem_x_ff, rem_y_ff, div_ff;
   logic [L1W-1:0]        rem_x_in, rem_y_in;
   logic [SNORM_BITS-1:0] word_x_ff, word_y_ff, word_x_in, word_y_in;
   side_type              side_ff;
   logic [L1W:0]          trial_x, trial_y, dvs;
   logic                  ge_x, ge_y;

   assign up_ready = !valid_ff || dn_ready;

   // One restoring step per coordinate: bring in the next dividend bit, subtract if it fits,
   // and shift the quotient bit in where the dividend bit left.
   always_comb begin
      dvs     = {1'b0, up_div};
      trial_x = {up_rem_x, up_word_x[SNORM_BITS-1]};
      trial_y = {up_rem_y, up_word_y[SNORM_BITS-1]};
      ge_x    = trial_x >= dvs;
      ge_y    = trial_y >= dvs;
      rem_x_in  = ge_x ? L1W'(trial_x - dvs) : trial_x[L1W-1:0];
      rem_y_in  = ge_y ? L1W'(trial_y - dvs) : trial_y[L1W-1:0];
      word_x_in = {up_word_x[SNORM_BITS-2:0], ge_x};
      word_y_in = {up_word_y[SNORM_BITS-2:0], ge_y};
      valid_in  = up_ready ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         rem_x_ff  <= rem_x_in;
         rem_y_ff  <= rem_y_in;
         word_x_ff <= word_x_in;
         word_y_ff <= word_y_in;
         div_ff    <= up_div;
         side_ff   <= up_side;
      end
   end

   assign dn_valid  = valid_ff;
   assign dn_rem_x  = rem_x_ff;
   assign dn_rem_y  = rem_y_ff;
   assign dn_word_x = word_x_ff;
   assign dn_word_y = word_y_ff;
   assign dn_div    = div_ff;
   assign dn_side   = side_ff;

endmodule

`default_nettype wire

// ===== design/oct_final.sv =====
`default_nettype none

module oct_final #(
   parameter int COMPONENT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              up_valid,
   output logic                              up_ready,
   input  logic [COMPONENT_BITS:0]           up_rem_x,
   input  logic [COMPONENT_BITS:0]           up_rem_y,
   input  logic [oct_pkg::SNORM_BITS-1:0]    up_word_x,
   input  logic [oct_pkg::SNORM_BITS-1:0]    up_word_y,
   input  logic [COMPONENT_BITS:0]           up_div,
   input  oct_pkg::side_type                 up_side,
   oct_rsp_if.source                         dn
);
   import oct_pkg::*;

   localparam int L1W = COMPONENT_BITS + 1;

   logic                  valid_ff, valid_in;
   logic [31:0]           data_ff, data_in;
   logic [L1W:0]          trial_x, trial_y, dvs;
   logic [SNORM_BITS-1:0] q_x, q_y;
   logic [HALF_BITS-1:0]  mag_x, mag_y, coord_x, coord_y;
   logic                  zero_norm;

   assign up_ready = !valid_ff || dn.ready;

   // last quotient bit, then sign and pack; a zero norm gives a zero result
   always_comb begin
      dvs       = {1'b0, up_div};
      trial_x   = {up_rem_x, up_word_x[SNORM_BITS-1]};
      trial_y   = {up_rem_y, up_word_y[SNORM_BITS-1]};
      q_x       = {up_word_x[SNORM_BITS-2:0], trial_x >= dvs};
      q_y       = {up_word_y[SNORM_BITS-2:0], trial_y >= dvs};
      mag_x     = HALF_BITS'(q_x);
      mag_y     = HALF_BITS'(q_y);
      zero_norm = up_div == '0;
      coord_x   = up_side.neg_x ? ('0 - mag_x) : mag_x;
      coord_y   = up_side.neg_y ? ('0 - mag_y) : mag_y;
      data_in   = zero_norm ? '0 : {coord_y, coord_x};
      valid_in  = up_ready ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn.valid         = valid_ff;
   assign dn.packed_normal = data_ff;

endmodule

`default_nettype wire

// ===== design/octahedral_normal_encoder.sv =====
// Channel   Dir  Payload                                Transaction when
// req_chan  in   dir_x, dir_y, dir_z (COMPONENT_BITS)   valid && ready
// rsp_chan  out  packed_normal[31:0] (y high, x low)    valid && ready
//
// One transaction per cycle sustained while the response side is ready.
// The divider resolves 15 quotient bits, one restoring step per cell and the last
// in the output stage, behind three front stages (magnitude, L1 norm, dividend).
// Reset (synchronous, active high) clears only the stage valid bits.
// Every stage holds when it is full and its neighbor stalls; empty stages
// keep filling, so a stalled result does not block new requests until the chain is full.
`default_nettype none

module octahedral_normal_encoder #(
   parameter int COMPONENT_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   oct_req_if.sink   req_chan,
   oct_rsp_if.source rsp_chan
);
   import oct_pkg::*;

   localparam int L1_BITS = COMPONENT_BITS + 1;

   // link i feeds divider cell i; the last link feeds the output stage
   logic                  link_valid  [SNORM_BITS];
   logic                  link_ready  [SNORM_BITS];
   logic [L1_BITS-1:0]    link_rem_x  [SNORM_BITS];
   logic [L1_BITS-1:0]    link_rem_y  [SNORM_BITS];
   logic [SNORM_BITS-1:0] link_word_x [SNORM_BITS];
   logic [SNORM_BITS-1:0] link_word_y [SNORM_BITS];
   logic [L1_BITS-1:0]    link_div    [SNORM_BITS];
   side_type              link_side   [SNORM_BITS];

   // front stages: magnitudes, fold, L1 norm, dividends
   oct_prep #(.COMPONENT_BITS(COMPONENT_BITS)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .up        (req_chan),
      .dn_valid  (link_valid[0]),
      .dn_ready  (link_ready[0]),
      .dn_rem_x  (link_rem_x[0]),
      .dn_rem_y  (link_rem_y[0]),
      .dn_word_x (link_word_x[0]),
      .dn_word_y (link_word_y[0]),
      .dn_div    (link_div[0]),
      .dn_side   (link_side[0])
   );

   // divider chain: each cell resolves one quotient bit of both coordinates
   for (genvar i = 0; i < SNORM_BITS - 1; i++) begin : g_cell
      oct_div_cell #(.COMPONENT_BITS(COMPONENT_BITS)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .up_valid  (link_valid[i]),
         .up_ready  (link_ready[i]),
         .up_rem_x  (link_rem_x[i]),
         .up_rem_y  (link_rem_y[i]),
         .up_word_x (link_word_x[i]),
         .up_word_y (link_word_y[i]),
         .up_div    (link_div[i]),
         .up_side   (link_side[i]),
         .dn_valid  (link_valid[i+1]),
         .dn_ready  (link_ready[i+1]),
         .dn_rem_x  (link_rem_x[i+1]),
         .dn_rem_y  (link_rem_y[i+1]),
         .dn_word_x (link_word_x[i+1]),
         .dn_word_y (link_word_y[i+1]),
         .dn_div    (link_div[i+1]),
         .dn_side   (link_side[i+1])
      );
   end

   // final bit, sign, zero-norm override, output register
   oct_final #(.COMPONENT_BITS(COMPONENT_BITS)) u_final (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (link_valid[SNORM_BITS-1]),
      .up_ready  (link_ready[SNORM_BITS-1]),
      .up_rem_x  (link_rem_x[SNORM_BITS-1]),
      .up_rem_y  (link_rem_y[SNORM_BITS-1]),
      .up_word_x (link_word_x[SNORM_BITS-1]),
      .up_word_y (link_word_y[SNORM_BITS-1]),
      .up_div    (link_div[SNORM_BITS-1]),
      .up_side   (link_side[SNORM_BITS-1]),
      .dn        (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== design/oct_checker.sv =====
`default_nettype none
`include "octahedral_normal_encoder_assert.svh"

module oct_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_packed_normal
);
   import oct_pkg::*;

   localparam int CW = $clog2(PIPE_DEPTH + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // track transactions in flight
   always_comb begin
      count_in = count_ff + CW'(req_fire) - CW'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   `OCT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_packed_normal))
   `OCT_ASSERT_IMP(a_no_spurious_rsp, clock, reset, rsp_valid, count_ff != '0)
   `OCT_ASSERT_IMP(a_depth_bound, clock, reset, 1'b1, count_ff <= CW'(PIPE_DEPTH))
   `OCT_ASSERT_IMP(a_snorm_range, clock, reset, rsp_valid, rsp_packed_normal[15:0] != 16'h8000 && rsp_packed_normal[31:16] != 16'h8000)

endmodule

bind octahedral_normal_encoder oct_checker u_oct_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_packed_normal (rsp_chan.packed_normal)
);

`default_nettype wire
